// File: src/sqb_pkg.sv
// Package: shared widths, state encoding and constants for the bisection square root.
package sqb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int INT_BITS  = 16;
  localparam int OP_BITS   = INT_BITS + FRAC_BITS;
  localparam int HALF_INT  = (INT_BITS + 1) / 2;
  // integer bracket search bounds run from 1 up to 2**HALF_INT
  localparam int SRCH_W    = HALF_INT + 1;
  localparam int SRCH_CW   = 2 * SRCH_W + FRAC_BITS;
  // guess width: the upper bound reaches 2**HALF_INT in Q.FRAC_BITS
  localparam int GW        = HALF_INT + FRAC_BITS + 1;
  localparam int SQ_W      = 2 * GW;
  localparam int TOL_W     = 32;
  localparam int ROOT_W    = 25;
  localparam int TOL_RST   = 66;
  // operand +/- tolerance, one guard bit
  localparam int T_W       = ((OP_BITS > TOL_W) ? OP_BITS : TOL_W) + 1;
  localparam int CMP_W     = ((SQ_W > T_W + FRAC_BITS) ? SQ_W : T_W + FRAC_BITS);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SRCH_MUL = 6'b000010,
    ST_SRCH_CMP = 6'b000100,
    ST_BIS_MUL  = 6'b001000,
    ST_BIS_CMP  = 6'b010000,
    ST_DONE     = 6'b100000
  } state_t;

endpackage

// File: src/sqb_ifs.sv
// Interfaces: request, result and tolerance-write channels of the square root block.
interface sqb_in_if;
  logic                           valid;
  logic                           ready;
  logic [sqb_pkg::OP_BITS-1:0]    operand;
  modport source (output valid, output operand, input ready);
  modport sink   (input valid, input operand, output ready);
endinterface

interface sqb_out_if;
  logic                           valid;
  logic                           ready;
  logic [sqb_pkg::ROOT_W-1:0]     root;
  logic                           converged;
  modport source (output valid, output root, output converged, input ready);
  modport sink   (input valid, input root, input converged, output ready);
endinterface

interface sqb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sqb_pkg::TOL_W-1:0]      data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/sqrt_bisection.sv
// Steps: an integer bracket search (always 8 steps) then bisection (1 to FRAC_BITS
//   steps); each step is a multiply state followed by a compare state.
// Throughput: one request at a time; the next request is taken the cycle after the
//   result is taken. The single
//   shared squaring multiplier sets the pace.
// Reset: synchronous active-low rst_n returns to idle and loads tolerance 66 (Q16.16).
module sqrt_bisection (
  input  logic            clk,
  input  logic            rst_n,
  sqb_in_if.sink          in_req,
  sqb_out_if.source       out_res,
  sqb_cfg_if.sink         cfg_wr
);

  sqb_pkg::state_t                state_r, state_nxt;

  // tolerance register, to be written only while idle; the block itself does not enforce this
  logic [sqb_pkg::TOL_W-1:0]      tol_r;

  // operand and precomputed acceptance window (operand +/- tolerance)
  logic [sqb_pkg::OP_BITS-1:0]    x_r, x_nxt;
  logic [sqb_pkg::T_W-1:0]        thi_r, thi_nxt;
  logic [sqb_pkg::T_W-2:0]        tlo_r, tlo_nxt;
  logic                           tlo_neg_r, tlo_neg_nxt;
  logic [sqb_pkg::T_W-1:0]        tlo_full;

  // integer bracket bounds
  logic [sqb_pkg::SRCH_W-1:0]     a_r, a_nxt, b_r, b_nxt;

  // shared multiplier: operand (midpoint or guess) and registered square
  logic [sqb_pkg::GW-1:0]         mul_op_r, mul_op_nxt;
  logic [sqb_pkg::SQ_W-1:0]       sq_r, sq_nxt;

  // half width of the current bisection interval, one-hot
  logic [sqb_pkg::FRAC_BITS-1:0]  h_r, h_nxt;
  logic [sqb_pkg::GW-1:0]         step;

  // output register
  logic [sqb_pkg::ROOT_W-1:0]     root_r, root_nxt;
  logic                           conv_r, conv_nxt;

  // comparisons
  logic [sqb_pkg::SRCH_CW-1:0]    srch_sq, srch_x;
  logic                           srch_ge;
  logic [sqb_pkg::CMP_W-1:0]      cmp_sq, cmp_tgt, cmp_hi, cmp_lo;
  logic                           sq_gt, in_hi, in_lo, hit;

  logic                           in_acc, out_acc;

  assign in_req.ready  = (state_r == sqb_pkg::ST_IDLE);
  assign out_res.valid = (state_r == sqb_pkg::ST_DONE);
  assign out_res.root  = root_r;
  assign out_res.converged = conv_r;
  assign cfg_wr.ready  = 1'b1;

  assign in_acc  = in_req.valid & in_req.ready;
  assign out_acc = out_res.valid & out_res.ready;

  // the one multiplier, registered before any use of its product
  assign sq_nxt = mul_op_r * mul_op_r;

  // integer search: is m*m (as Q.FRAC) at least the operand
  assign srch_sq = sqb_pkg::SRCH_CW'(sq_r[2*sqb_pkg::SRCH_W-1:0]) << sqb_pkg::FRAC_BITS;
  assign srch_x  = sqb_pkg::SRCH_CW'(x_r);
  assign srch_ge = (srch_sq >= srch_x);

  // bisection: square has 2*FRAC fraction bits, shift the window to match
  assign cmp_sq  = sqb_pkg::CMP_W'(sq_r);
  assign cmp_tgt = sqb_pkg::CMP_W'(x_r) << sqb_pkg::FRAC_BITS;
  assign cmp_hi  = sqb_pkg::CMP_W'(thi_r) << sqb_pkg::FRAC_BITS;
  assign cmp_lo  = sqb_pkg::CMP_W'(tlo_r) << sqb_pkg::FRAC_BITS;
  assign sq_gt   = (cmp_sq > cmp_tgt);
  assign in_hi   = (cmp_sq <= cmp_hi);
  assign in_lo   = tlo_neg_r | (cmp_sq >= cmp_lo);
  assign hit     = in_hi & in_lo;

  assign tlo_full = sqb_pkg::T_W'(in_req.operand[sqb_pkg::OP_BITS-1:0])
                  - sqb_pkg::T_W'(tol_r);
  assign step     = sqb_pkg::GW'(h_r >> 1);

  always_comb begin
    state_nxt   = state_r;
    x_nxt       = x_r;
    thi_nxt     = thi_r;
    tlo_nxt     = tlo_r;
    tlo_neg_nxt = tlo_neg_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    mul_op_nxt  = mul_op_r;
    h_nxt       = h_r;
    root_nxt    = root_r;
    conv_nxt    = conv_r;
    unique case (state_r)
      sqb_pkg::ST_IDLE: begin
        if (in_acc) begin
          // latch operand, build the tolerance window, start bracket [1, 2**HALF_INT]
          x_nxt       = in_req.operand[sqb_pkg::OP_BITS-1:0];
          thi_nxt     = sqb_pkg::T_W'(in_req.operand[sqb_pkg::OP_BITS-1:0])
                      + sqb_pkg::T_W'(tol_r);
          tlo_nxt     = tlo_full[sqb_pkg::T_W-2:0];
          tlo_neg_nxt = tlo_full[sqb_pkg::T_W-1];
          a_nxt       = sqb_pkg::SRCH_W'(1);
          b_nxt       = sqb_pkg::SRCH_W'(1) << sqb_pkg::HALF_INT;
          mul_op_nxt  = sqb_pkg::GW'((sqb_pkg::SRCH_W + 1)'(1)
                      + ((sqb_pkg::SRCH_W + 1)'(1) << sqb_pkg::HALF_INT)) >> 1;
          state_nxt   = sqb_pkg::ST_SRCH_MUL;
        end
      end
      sqb_pkg::ST_SRCH_MUL: begin
        state_nxt = sqb_pkg::ST_SRCH_CMP;
      end
      sqb_pkg::ST_SRCH_CMP: begin
        // narrow the integer bracket around the smallest h with h*h >= operand
        if (srch_ge) begin
          b_nxt = mul_op_r[sqb_pkg::SRCH_W-1:0];
        end else begin
          a_nxt = mul_op_r[sqb_pkg::SRCH_W-1:0] + sqb_pkg::SRCH_W'(1);
        end
        if (a_nxt < b_nxt) begin
          mul_op_nxt = sqb_pkg::GW'(((sqb_pkg::SRCH_W + 1)'(a_nxt)
                     + (sqb_pkg::SRCH_W + 1)'(b_nxt)) >> 1);
          state_nxt  = sqb_pkg::ST_SRCH_MUL;
        end else begin
          // first guess is the midpoint of [h-1, h]
          mul_op_nxt = (sqb_pkg::GW'(a_nxt - sqb_pkg::SRCH_W'(1)) << sqb_pkg::FRAC_BITS)
                     | (sqb_pkg::GW'(1) << (sqb_pkg::FRAC_BITS - 1));
          h_nxt      = sqb_pkg::FRAC_BITS'(1) << (sqb_pkg::FRAC_BITS - 1);
          state_nxt  = sqb_pkg::ST_BIS_MUL;
        end
      end
      sqb_pkg::ST_BIS_MUL: begin
        state_nxt = sqb_pkg::ST_BIS_CMP;
      end
      sqb_pkg::ST_BIS_CMP: begin
        if (hit) begin
          root_nxt  = sqb_pkg::ROOT_W'(mul_op_r);
          conv_nxt  = 1'b1;
          state_nxt = sqb_pkg::ST_DONE;
        end else if (h_r[0]) begin
          // interval is one LSB wide after this replacement: give up
          root_nxt  = sqb_pkg::ROOT_W'(mul_op_r);
          conv_nxt  = 1'b0;
          state_nxt = sqb_pkg::ST_DONE;
        end else begin
          // replace the bound on the wrong side; new midpoint is guess -/+ quarter width
          h_nxt      = h_r >> 1;
          mul_op_nxt = sq_gt ? (mul_op_r - step) : (mul_op_r + step);
          state_nxt  = sqb_pkg::ST_BIS_MUL;
        end
      end
      sqb_pkg::ST_DONE: begin
        if (out_acc) begin
          state_nxt = sqb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sqb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sqb_pkg::ST_IDLE;
      tol_r   <= sqb_pkg::TOL_W'(sqb_pkg::TOL_RST);
    end else begin
      state_r <= state_nxt;
      if (cfg_wr.valid & cfg_wr.ready) begin
        tol_r <= cfg_wr.data;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    thi_r     <= thi_nxt;
    tlo_r     <= tlo_nxt;
    tlo_neg_r <= tlo_neg_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    mul_op_r  <= mul_op_nxt;
    h_r       <= h_nxt;
    root_r    <= root_nxt;
    conv_r    <= conv_nxt;
    if ((state_r == sqb_pkg::ST_SRCH_MUL) || (state_r == sqb_pkg::ST_BIS_MUL)) begin
      sq_r <= sq_nxt;
    end
  end

endmodule

// File: src/sqb_checker.sv
// Checker: port-level temporal checks for the square root block, bound to the top level.
module sqb_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [sqb_pkg::ROOT_W-1:0]   root
);

  // one request in flight: never ready for a new request while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request accepted while result pending");

  // a taken request closes the input side next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still ready after request");

  // a taken result clears the output next cycle
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> !out_valid)
    else $error("result repeated");

  // a stalled result holds
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(root)))
    else $error("stalled result dropped or changed");

endmodule

bind sqrt_bisection sqb_checker u_sqb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .root      (out_res.root)
);
